// File: rtl/byte_ring_buffer_dma_windows_top_macros.svh
// ----------------------------------------------------------------------------
// byte_ring_buffer_dma_windows_top_macros
// Assertion macros used by the checker of the byte ring buffer.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_DMA_WINDOWS_TOP_MACROS_SVH
`define BYTE_RING_BUFFER_DMA_WINDOWS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BRB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brbdma: implication check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brbdma: next-cycle check failed");

`endif

// File: rtl/brbdma_pkg.sv
// ----------------------------------------------------------------------------
// brbdma_pkg
// Command codes and fixed field widths of the byte ring buffer with DMA windows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brbdma_pkg;

  localparam int unsigned ItemW  = 8;  // width of a stored byte
  localparam int unsigned CountW = 8;  // width of a DMA count
  localparam int unsigned FieldW = 8;  // width of the index and level results

  typedef enum logic [2:0] {
    CMD_PUSH       = 3'd0,
    CMD_POP        = 3'd1,
    CMD_IN_WINDOW  = 3'd2,
    CMD_IN_COMMIT  = 3'd3,
    CMD_OUT_WINDOW = 3'd4,
    CMD_OUT_COMMIT = 3'd5
  } cmd_e;

endpackage

`default_nettype wire

// File: rtl/byte_ring_buffer_dma_windows_top.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_dma_windows_top
// Byte FIFO in a ring of CAPACITY+1 slots with DMA window report and commit.
// ----------------------------------------------------------------------------
// A command is taken at every rising edge with start_i high; busy_o stays low,
// so one push, pop, window query or commit enters per clock. Its result shows
// on the result ports for one cycle, flagged by strobe_o, in the cycle right
// after the command was taken, as set by the registered read port of the
// slot memory. The receiver cannot stall the block, so a result that is not
// sampled in its strobe cycle is gone. A push when full, a pop when empty and
// a commit larger than the free or filled space are refused (accepted_o low,
// nothing changes). fill_level_o gives the number of bytes held after the
// transaction. A slot that a DMA input commit skipped over holds whatever the
// memory held; popping it returns that content. No clearing pass is run
// after reset: the read and write indices alone say what is valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_dma_windows_top
  import brbdma_pkg::*;
#(
  parameter int unsigned CAPACITY = 255
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [2:0]        command_i,
  input  wire logic [ItemW-1:0]  item_in_i,
  input  wire logic [CountW-1:0] count_i,
  output logic                   strobe_o,
  output logic [ItemW-1:0]       read_data_o,
  output logic                   accepted_o,
  output logic [FieldW-1:0]      window_start_o,
  output logic [FieldW-1:0]      window_length_o,
  output logic [FieldW-1:0]      fill_level_o
);

  // Ring geometry: IDX_W indexes the slots, SUM_W holds an index plus a count
  // and the slot total itself without overflow.
  localparam int unsigned SLOTS = CAPACITY + 1;
  localparam int unsigned IDX_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
  localparam int unsigned WIDE  = (IDX_W > FieldW) ? IDX_W : FieldW;
  localparam int unsigned SUM_W = WIDE + 1;
  localparam logic [SUM_W-1:0] SLOTS_S = SUM_W'(SLOTS);
  localparam logic [SUM_W-1:0] CAP_S   = SUM_W'(CAPACITY);

  // Slot memory: one write port, one registered read port.
  logic [ItemW-1:0] mem_q [SLOTS];
  logic [ItemW-1:0] rdata_q;

  // Ring state: indices and a running fill count.
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic [IDX_W-1:0] widx_q, widx_d;
  logic [IDX_W-1:0] fill_q, fill_d;

  // Result registers.
  logic              strobe_q;
  logic              pop_ok_q;
  logic              acc_q, acc_d;
  logic [FieldW-1:0] wstart_q, wstart_d;
  logic [FieldW-1:0] wlen_q, wlen_d;

  logic             take;
  cmd_e             cmd;
  logic [SUM_W-1:0] r_s, w_s, fill_s, cnt_s, free_s;
  logic             full, empty;
  logic             push_ok, pop_ok, in_ok, out_ok;
  logic [SUM_W-1:0] step;
  logic [SUM_W-1:0] w_sum, r_sum, w_wrap, r_wrap;
  logic [SUM_W-1:0] in_len, out_len;

  // Every command is taken on its own cycle; nothing is ever held off.
  assign busy_o = 1'b0;
  assign take   = start_i;
  assign cmd    = cmd_e'(command_i);

  assign r_s    = SUM_W'(ridx_q);
  assign w_s    = SUM_W'(widx_q);
  assign fill_s = SUM_W'(fill_q);
  assign cnt_s  = SUM_W'(count_i);
  assign free_s = CAP_S - fill_s;
  assign full   = (fill_s == CAP_S);
  assign empty  = (fill_q == '0);

  assign push_ok = (cmd == CMD_PUSH) && !full;
  assign pop_ok  = (cmd == CMD_POP) && !empty;
  assign in_ok   = (cmd == CMD_IN_COMMIT) && (cnt_s <= free_s);
  assign out_ok  = (cmd == CMD_OUT_COMMIT) && (cnt_s <= fill_s);

  // One shared step size: a single byte for push and pop, the DMA count else.
  assign step   = (push_ok || pop_ok) ? SUM_W'(1) : cnt_s;
  assign w_sum  = w_s + step;
  assign r_sum  = r_s + step;
  // The sum stays below twice the slot count, so one subtract wraps it.
  assign w_wrap = (w_sum >= SLOTS_S) ? (w_sum - SLOTS_S) : w_sum;
  assign r_wrap = (r_sum >= SLOTS_S) ? (r_sum - SLOTS_S) : r_sum;

  // Free window from the write index: up to the ring end when the write index
  // leads (an empty ring too), keeping the last slot free if the read index
  // sits at slot 0; else up to one short of the read index.
  always_comb begin
    if (full) begin
      in_len = '0;
    end else if (w_s >= r_s) begin
      in_len = SLOTS_S - w_s - ((r_s == '0) ? SUM_W'(1) : SUM_W'(0));
    end else begin
      in_len = r_s - w_s - SUM_W'(1);
    end
  end

  // Filled window from the read index: up to the write index, or to the ring
  // end when the data wraps.
  always_comb begin
    if (empty) begin
      out_len = '0;
    end else if (w_s > r_s) begin
      out_len = w_s - r_s;
    end else begin
      out_len = SLOTS_S - r_s;
    end
  end

  always_comb begin
    widx_d   = widx_q;
    ridx_d   = ridx_q;
    fill_d   = fill_q;
    acc_d    = 1'b0;
    wstart_d = '0;
    wlen_d   = '0;
    unique case (cmd)
      CMD_PUSH: begin
        if (push_ok) begin
          widx_d = w_wrap[IDX_W-1:0];
          fill_d = fill_q + IDX_W'(1);
          acc_d  = 1'b1;
        end
      end
      CMD_POP: begin
        if (pop_ok) begin
          ridx_d = r_wrap[IDX_W-1:0];
          fill_d = fill_q - IDX_W'(1);
          acc_d  = 1'b1;
        end
      end
      CMD_IN_WINDOW: begin
        acc_d    = 1'b1;
        wstart_d = w_s[FieldW-1:0];
        wlen_d   = in_len[FieldW-1:0];
      end
      CMD_IN_COMMIT: begin
        if (in_ok) begin
          widx_d = w_wrap[IDX_W-1:0];
          fill_d = IDX_W'(fill_s + cnt_s);
          acc_d  = 1'b1;
        end
      end
      CMD_OUT_WINDOW: begin
        acc_d    = 1'b1;
        wstart_d = r_s[FieldW-1:0];
        wlen_d   = out_len[FieldW-1:0];
      end
      CMD_OUT_COMMIT: begin
        if (out_ok) begin
          ridx_d = r_wrap[IDX_W-1:0];
          fill_d = IDX_W'(fill_s - cnt_s);
          acc_d  = 1'b1;
        end
      end
      default: begin
        // Unused codes: refuse and leave the ring untouched.
        acc_d = 1'b0;
      end
    endcase
  end

  // Write the pushed byte; fetch the byte at the read index for a pop. A slot
  // written by a push is read only by a later pop, so no bypass.
  always_ff @(posedge clk_i) begin
    if (take && push_ok) begin
      mem_q[widx_q] <= item_in_i;
    end
    if (take && pop_ok) begin
      rdata_q <= mem_q[ridx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ridx_q   <= '0;
      widx_q   <= '0;
      fill_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= take;
      if (take) begin
        ridx_q <= ridx_d;
        widx_q <= widx_d;
        fill_q <= fill_d;
      end
    end
  end

  // Hold the result fields for the strobe cycle.
  always_ff @(posedge clk_i) begin
    if (take) begin
      pop_ok_q <= pop_ok;
      acc_q    <= acc_d;
      wstart_q <= wstart_d;
      wlen_q   <= wlen_d;
    end
  end

  // The level register already holds the post-transaction count in the strobe
  // cycle, since it updated at the same edge that took the command.
  assign strobe_o        = strobe_q;
  assign read_data_o     = pop_ok_q ? rdata_q : '0;
  assign accepted_o      = acc_q;
  assign window_start_o  = wstart_q;
  assign window_length_o = wlen_q;
  assign fill_level_o    = fill_s[FieldW-1:0];

endmodule

`default_nettype wire

// File: rtl/brbdma_checker.sv
// ----------------------------------------------------------------------------
// brbdma_checker
// Port-level checks on the byte ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "byte_ring_buffer_dma_windows_top_macros.svh"

module brbdma_checker
  import brbdma_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic [2:0]        command_i,
  input wire logic              strobe_o,
  input wire logic [ItemW-1:0]  read_data_o,
  input wire logic              accepted_o,
  input wire logic [FieldW-1:0] window_start_o,
  input wire logic [FieldW-1:0] window_length_o,
  input wire logic [FieldW-1:0] fill_level_o
);

  // Each taken transaction gives exactly one strobe, in the next cycle.
  `BRB_ASSERT_NEXT(a_strobe_follows, start_i && !busy_o, strobe_o)
  `BRB_ASSERT_IMPL(a_strobe_has_cause, strobe_o, $past(start_i && !busy_o))

  // Only a window query reports a window.
  `BRB_ASSERT_IMPL(a_window_only_query,
                   strobe_o && !($past(command_i) == CMD_IN_WINDOW ||
                                 $past(command_i) == CMD_OUT_WINDOW),
                   window_start_o == '0 && window_length_o == '0)

  // A taken push raises the level by one; a refused pop returns zero data.
  `BRB_ASSERT_IMPL(a_push_level,
                   strobe_o && accepted_o && $past(command_i) == CMD_PUSH,
                   fill_level_o == FieldW'($past(fill_level_o) + 1'b1))
  `BRB_ASSERT_IMPL(a_refused_pop_zero, strobe_o && !accepted_o, read_data_o == '0)

endmodule

bind byte_ring_buffer_dma_windows_top brbdma_checker u_brbdma_checker (.*);

`default_nettype wire
